[hdl/sma_pkg.sv]
// Package holding the types, opcodes, and status codes of the stack machine ALU.
`default_nettype none
package sma_pkg;
    localparam int unsigned StackDepth = 1024;
    localparam int unsigned AddrW = $clog2(StackDepth);
    localparam int unsigned SpW = AddrW + 1;

    typedef enum logic [4:0] {
        OP_PUSH = 5'd0, OP_POP = 5'd1, OP_ADD = 5'd2, OP_SUB = 5'd3, OP_MUL = 5'd4,
        OP_DIV = 5'd5, OP_MOD = 5'd6, OP_AND = 5'd7, OP_OR = 5'd8, OP_XOR = 5'd9,
        OP_NOT = 5'd10, OP_SHL = 5'd11, OP_SHR = 5'd12, OP_POW = 5'd13, OP_LT = 5'd14,
        OP_GT = 5'd15, OP_EQ = 5'd16, OP_DUP = 5'd17, OP_OVER = 5'd18, OP_SWAP = 5'd19,
        OP_LAND = 5'd20, OP_LOR = 5'd21, OP_LNOT = 5'd22, OP_DEPTH = 5'd23,
        OP_PICK = 5'd24
    } op_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_OVERFLOW = 3'd1, ST_UNDERFLOW = 3'd2, ST_NEG_EXP = 3'd3,
        ST_DIV_ZERO = 3'd4, ST_PICK_RANGE = 3'd5
    } status_t;

    typedef struct packed {
        logic [4:0]         op;
        logic signed [63:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] result_value;
        logic [2:0]         status;
        logic [10:0]        stack_depth;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_B, S_RD_A, S_WAIT_A, S_PICK_RD, S_PICK_WAIT, S_MUL, S_ITER,
        S_WR1, S_WR2, S_TOP_RD, S_TOP_WAIT, S_OUT
    } state_t;

    // Command to the multicycle arithmetic unit.
    typedef struct packed {
        logic start;
        logic [1:0] kind; // 0 mul, 1 div, 2 mod, 3 pow
    } arith_cmd_t;

    localparam logic [1:0] K_MUL = 2'd0;
    localparam logic [1:0] K_DIV = 2'd1;
    localparam logic [1:0] K_MOD = 2'd2;
    localparam logic [1:0] K_POW = 2'd3;
endpackage
`default_nettype wire

[hdl/sma_mul.sv]
// Multicycle 64x64 wrapping multiplier built from 32x32 partial products.
`default_nettype none
module sma_mul
    import sma_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      p
);
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] a_reg, b_reg;
    logic [63:0] prod;
    logic [31:0] x, y;
    logic        done_reg;

    always_comb
    begin
        unique case (step_reg)
            2'd0: begin x = a_reg[31:0];  y = b_reg[31:0];  end
            2'd1: begin x = a_reg[63:32]; y = b_reg[31:0];  end
            default: begin x = a_reg[31:0]; y = b_reg[63:32]; end
        endcase
        prod = {32'd0, x} * {32'd0, y};
        acc_next = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            if (step_reg == 2'd0)
                acc_next = prod;
            else
                acc_next = acc_reg + {prod[31:0], 32'd0};
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd2)
            begin
                busy_next = 1'b0;
            end
        end
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
        end
        p = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= busy_reg && step_reg == 2'd2;
    end
    assign done = done_reg;

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
    end
endmodule
`default_nettype wire

[hdl/stack_machine_alu.sv]
// Top level of the stack machine ALU: stack memory, sequencer and arithmetic.
// Usage: one operation arrives per transfer on the input channel (in_valid, in_stall,
// in_data); exactly one result leaves per operation on the output channel (out_valid,
// out_stall, out_data). The block works on one operation at a time.
// The stack lives in a 1024-word synchronous RAM with a registered read port; only the
// stack pointer is kept in a register, so operands and the new top are read back.
// Mul forms its product from three 32x32 partial products; div and mod produce one
// quotient bit per cycle; pow works through the exponent one bit at a time, with a
// multiply and a square per bit. Divide by zero and negative exponent report without
// iterating. The next input transfer is taken in the cycle after the result is loaded.
// Reset clears the stack pointer, the sequencer state and out_valid; the stack contents are
// undefined until written. While the receiver stalls, the result waits in the output
// register; the next operation may still be taken and runs up to its result, which
// then holds in_stall high until the output register is free.
`default_nettype none
module stack_machine_alu
    import sma_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data
);
    // Stack memory.
    logic [63:0] mem [StackDepth];
    logic             we;
    logic [AddrW-1:0] waddr, raddr;
    logic [63:0]      wdata, rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    state_t state_reg, state_next;
    logic [SpW-1:0] sp_reg, sp_next;
    logic [4:0]     op_reg;
    logic [63:0]    pv_reg, b_reg, a_reg, r_reg, w2_reg;
    logic [63:0]    b_next, a_next, r_next, w2_next;
    logic [SpW-1:0] wa1_reg, wa1_next, wa2_reg, wa2_next;
    logic           two_reg, two_next;
    logic [2:0]     st_reg, st_next;
    logic           popped_reg, popped_next;
    logic           out_valid_reg, out_valid_next;
    out_item_t      out_reg, out_next;

    // Iterative unit registers (divider and power).
    logic [63:0] q_reg, q_next, rem_reg, rem_next, dv_reg, dv_next;
    logic [63:0] base_reg, base_next, e_reg, e_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        phase_reg, phase_next; // pow: 0 multiply result, 1 square base

    // Multiplier.
    logic        mstart;
    logic [63:0] ma, mb, mp;
    logic        mdone;
    sma_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb),
                   .done(mdone), .p(mp));

    logic [4:0] cur_op;
    logic [63:0] sb;
    logic [64:0] trial;
    logic [SpW-1:0] tmp_sp;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        sp_next = sp_reg;
        b_next = b_reg; a_next = a_reg; r_next = r_reg; w2_next = w2_reg;
        wa1_next = wa1_reg; wa2_next = wa2_reg; two_next = two_reg;
        st_next = st_reg; popped_next = popped_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next = out_reg;
        q_next = q_reg; rem_next = rem_reg; dv_next = dv_reg;
        base_next = base_reg; e_next = e_reg; cnt_next = cnt_reg;
        phase_next = phase_reg;
        we = 1'b0; waddr = '0; wdata = '0;
        raddr = AddrW'(sp_reg - SpW'(1));
        mstart = 1'b0; ma = a_reg; mb = b_reg;
        cur_op = op_reg;
        sb = b_reg[63] ? (~b_reg + 64'd1) : b_reg;
        trial = {rem_reg, q_reg[63]} - {1'b0, dv_reg};
        tmp_sp = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cur_op = in_data.op;
                    st_next = ST_OK; popped_next = 1'b0; two_next = 1'b0;
                    raddr = AddrW'(sp_reg - SpW'(1));
                    state_next = S_RD_B;
                end
            end
            S_RD_B:
            begin
                // Read the top word; it arrives in the next cycle.
                raddr = AddrW'(sp_reg - SpW'(1));
                state_next = S_RD_A;
            end
            S_RD_A:
            begin
                b_next = rdata_reg;
                raddr = (cur_op == OP_OVER) ? AddrW'(sp_reg - SpW'(3))
                                            : AddrW'(sp_reg - SpW'(2));
                state_next = S_WAIT_A;
                priority case (cur_op)
                    OP_PUSH, OP_DEPTH:
                        if (sp_reg >= SpW'(StackDepth)) begin st_next = ST_OVERFLOW;
                            state_next = S_TOP_RD; end
                        else begin
                            wa1_next = sp_reg;
                            r_next = (cur_op == OP_PUSH) ? pv_reg : 64'(sp_reg);
                            sp_next = sp_reg + SpW'(1);
                            state_next = S_WR1;
                        end
                    OP_POP:
                        if (sp_reg < SpW'(1)) begin st_next = ST_UNDERFLOW;
                            state_next = S_TOP_RD; end
                        else begin
                            popped_next = 1'b1; sp_next = sp_reg - SpW'(1);
                            state_next = S_OUT;
                        end
                    OP_NOT, OP_LNOT:
                        if (sp_reg < SpW'(1)) begin st_next = ST_UNDERFLOW;
                            state_next = S_TOP_RD; end
                        else begin
                            wa1_next = sp_reg - SpW'(1);
                            r_next = (cur_op == OP_NOT) ? ~rdata_reg
                                   : ((rdata_reg == 64'd0) ? 64'd1 : 64'd0);
                            state_next = S_WR1;
                        end
                    OP_DUP:
                        if (sp_reg < SpW'(1)) begin st_next = ST_UNDERFLOW;
                            state_next = S_TOP_RD; end
                        else if (sp_reg >= SpW'(StackDepth)) begin
                            st_next = ST_OVERFLOW; state_next = S_TOP_RD; end
                        else begin
                            wa1_next = sp_reg; r_next = rdata_reg;
                            sp_next = sp_reg + SpW'(1); state_next = S_WR1;
                        end
                    OP_PICK:
                        if (sp_reg < SpW'(1)) begin st_next = ST_UNDERFLOW;
                            state_next = S_TOP_RD; end
                        else if (rdata_reg >= 64'(sp_reg - SpW'(1))) begin
                            st_next = ST_PICK_RANGE; state_next = S_TOP_RD; end
                        else begin
                            raddr = AddrW'(rdata_reg);
                            state_next = S_PICK_WAIT;
                        end
                    OP_OVER:
                        if (sp_reg < SpW'(3)) begin st_next = ST_UNDERFLOW;
                            state_next = S_TOP_RD; end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
                    OP_SHL, OP_SHR, OP_POW, OP_LT, OP_GT, OP_EQ, OP_LAND, OP_LOR,
                    OP_SWAP:
                        if (sp_reg < SpW'(2)) begin st_next = ST_UNDERFLOW;
                            state_next = S_TOP_RD; end
                    default:
                        state_next = S_TOP_RD;
                endcase
            end
            S_WAIT_A:
            begin
                a_next = rdata_reg;
                state_next = S_WR1;
                two_next = 1'b0;
                wa1_next = sp_reg - SpW'(2);
                tmp_sp = sp_reg - SpW'(1);
                priority case (cur_op)
                    OP_ADD: r_next = rdata_reg + b_reg;
                    OP_SUB: r_next = rdata_reg - b_reg;
                    OP_AND: r_next = rdata_reg & b_reg;
                    OP_OR:  r_next = rdata_reg | b_reg;
                    OP_XOR: r_next = rdata_reg ^ b_reg;
                    OP_SHL: r_next = rdata_reg << b_reg[5:0];
                    OP_SHR: r_next = 64'($signed(rdata_reg) >>> b_reg[5:0]);
                    OP_LT:  r_next = {63'd0, $signed(rdata_reg) < $signed(b_reg)};
                    OP_GT:  r_next = {63'd0, $signed(rdata_reg) > $signed(b_reg)};
                    OP_EQ:  r_next = {63'd0, rdata_reg == b_reg};
                    OP_LAND: r_next = {63'd0, (rdata_reg != 0) && (b_reg != 0)};
                    OP_LOR:  r_next = {63'd0, (rdata_reg != 0) || (b_reg != 0)};
                    OP_SWAP, OP_OVER:
                    begin
                        r_next = rdata_reg; wa1_next = sp_reg - SpW'(1);
                        w2_next = b_reg; two_next = 1'b1;
                        wa2_next = (cur_op == OP_OVER) ? sp_reg - SpW'(3)
                                                       : sp_reg - SpW'(2);
                        tmp_sp = sp_reg;
                    end
                    OP_MUL:
                    begin
                        mstart = 1'b1; ma = rdata_reg; mb = b_reg;
                        state_next = S_MUL;
                    end
                    OP_DIV, OP_MOD:
                        if (b_reg == 64'd0) begin st_next = ST_DIV_ZERO;
                            state_next = S_TOP_RD; tmp_sp = sp_reg; end
                        else begin
                            q_next = rdata_reg[63] ? (~rdata_reg + 64'd1) : rdata_reg;
                            rem_next = '0; dv_next = sb; cnt_next = 7'd64;
                            state_next = S_ITER;
                        end
                    OP_POW:
                        if (b_reg[63]) begin st_next = ST_NEG_EXP;
                            state_next = S_TOP_RD; tmp_sp = sp_reg; end
                        else begin
                            r_next = 64'd1; base_next = rdata_reg; e_next = b_reg;
                            phase_next = 1'b0; state_next = S_ITER;
                        end
                    default: tmp_sp = sp_reg;
                endcase
                if (state_next == S_WR1)
                    sp_next = tmp_sp;
                else
                    sp_next = sp_reg;
            end
            S_PICK_RD: state_next = S_PICK_WAIT;
            S_PICK_WAIT:
            begin
                wa1_next = sp_reg - SpW'(1); r_next = rdata_reg;
                state_next = S_WR1;
            end
            S_MUL:
                if (mdone)
                begin
                    r_next = mp; sp_next = sp_reg - SpW'(1);
                    wa1_next = sp_reg - SpW'(2); state_next = S_WR1;
                end
            S_ITER:
            begin
                if (cur_op == OP_POW)
                begin
                    if (e_reg == 64'd0)
                    begin
                        sp_next = sp_reg - SpW'(1); wa1_next = sp_reg - SpW'(2);
                        state_next = S_WR1;
                    end
                    else if (!phase_reg)
                    begin
                        mstart = 1'b1; ma = r_reg; mb = base_reg;
                        phase_next = 1'b1;
                        cnt_next = 7'd1;
                    end
                    else if (cnt_reg != 7'd0)
                    begin
                        // Waiting for the result multiply, then square base.
                        if (mdone)
                        begin
                            if (e_reg[0]) r_next = mp;
                            mstart = 1'b1; ma = base_reg; mb = base_reg;
                            cnt_next = 7'd0;
                        end
                    end
                    else if (mdone)
                    begin
                        base_next = mp; e_next = e_reg >> 1; phase_next = 1'b0;
                    end
                end
                else
                begin
                    if (cnt_reg == 7'd0)
                    begin
                        sp_next = sp_reg - SpW'(1); wa1_next = sp_reg - SpW'(2);
                        if (cur_op == OP_DIV)
                            r_next = (a_reg[63] != b_reg[63]) ? (~q_reg + 64'd1) : q_reg;
                        else
                            r_next = a_reg[63] ? (~rem_reg + 64'd1) : rem_reg;
                        state_next = S_WR1;
                    end
                    else
                    begin
                        if (!trial[64])
                        begin
                            rem_next = trial[63:0];
                            q_next = {q_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            rem_next = {rem_reg[62:0], q_reg[63]};
                            q_next = {q_reg[62:0], 1'b0};
                        end
                        cnt_next = cnt_reg - 7'd1;
                    end
                end
            end
            S_WR1:
            begin
                we = 1'b1; waddr = AddrW'(wa1_reg); wdata = r_reg;
                state_next = two_reg ? S_WR2 : S_TOP_RD;
            end
            S_WR2:
            begin
                we = 1'b1; waddr = AddrW'(wa2_reg); wdata = w2_reg;
                state_next = S_TOP_RD;
            end
            S_TOP_RD:
            begin
                raddr = AddrW'(sp_reg - SpW'(1));
                state_next = S_TOP_WAIT;
            end
            S_TOP_WAIT:
            begin
                r_next = (sp_reg != '0) ? rdata_reg : 64'd0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next.result_value = popped_reg ? b_reg : r_reg;
                    out_next.status = st_reg;
                    out_next.stack_depth = 11'(sp_reg);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg <= in_data.op;
            pv_reg <= in_data.push_value;
        end
        b_reg <= b_next; a_reg <= a_next; r_reg <= r_next; w2_reg <= w2_next;
        wa1_reg <= wa1_next; wa2_reg <= wa2_next; two_reg <= two_next;
        st_reg <= st_next; popped_reg <= popped_next; out_reg <= out_next;
        q_reg <= q_next; rem_reg <= rem_next; dv_reg <= dv_next;
        base_reg <= base_next; e_reg <= e_next; cnt_reg <= cnt_next;
        phase_reg <= phase_next;
    end

    // The stack never grows beyond its capacity.
    assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= SpW'(StackDepth))
        else $error("stack pointer beyond capacity");
    // No new operation is taken while a result is being formed.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("input taken while busy");
    // The stack pointer only moves by at most one per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sp_reg == $past(sp_reg)) || (sp_reg == $past(sp_reg) + SpW'(1))
        || (sp_reg + SpW'(1) == $past(sp_reg)))
        else $error("stack pointer jumped");
endmodule
`default_nettype wire

[bench/tb.sv]
// Testbench for the stack machine ALU: directed table, random programs, and a scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import sma_pkg::*;

    localparam int unsigned Depth = StackDepth;
    localparam int RandomOps = 240;
    localparam int DrainCycles = 600;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    stack_machine_alu uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #4 clk = ~clk;

    // The predictor keeps its own copy of the stack.
    logic [63:0] model_stack [Depth];
    int unsigned model_sp;
    out_item_t   pending_results[$];
    int          error_count;
    int          checked_count;
    int          status_seen[6];
    int          send_idle_pct;
    int          recv_idle_pct;

    function automatic logic [63:0] signed_divide(logic [63:0] a, logic [63:0] b, bit want_rem);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] r;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        if (want_rem)
        begin
            r = ua % ub;
            return a[63] ? -r : r;
        end
        r = ua / ub;
        return (a[63] != b[63]) ? -r : r;
    endfunction

    function automatic logic [63:0] wrap_power(logic [63:0] base, logic [63:0] e);
        logic [63:0] r;
        r = 64'd1;
        while (e != 0)
        begin
            if (e[0])
                r = r * base;
            base = base * base;
            e = e >> 1;
        end
        return r;
    endfunction

    // Applies one operation to the model stack and returns the result it must produce.
    function automatic out_item_t stack_op_result(logic [4:0] op, logic [63:0] pv);
        out_item_t   res;
        int unsigned sp;
        logic [2:0]  st;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        logic [63:0] t;
        bit          popped;
        sp = model_sp;
        st = ST_OK;
        popped = 1'b0;
        r = '0;
        case (op)
            OP_PUSH:
                if (sp >= Depth) st = ST_OVERFLOW;
                else
                begin
                    model_stack[sp] = pv;
                    sp++;
                end
            OP_POP:
                if (sp < 1) st = ST_UNDERFLOW;
                else
                begin
                    sp--;
                    r = model_stack[sp];
                    popped = 1'b1;
                end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR, OP_SHL,
            OP_SHR, OP_POW, OP_LT, OP_GT, OP_EQ, OP_LAND, OP_LOR:
                if (sp < 2) st = ST_UNDERFLOW;
                else
                begin
                    b = model_stack[sp-1];
                    a = model_stack[sp-2];
                    case (op)
                        OP_ADD: t = a + b;
                        OP_SUB: t = a - b;
                        OP_MUL: t = a * b;
                        OP_DIV, OP_MOD:
                            if (b == 0) st = ST_DIV_ZERO;
                            else t = signed_divide(a, b, op == OP_MOD);
                        OP_AND: t = a & b;
                        OP_OR:  t = a | b;
                        OP_XOR: t = a ^ b;
                        OP_SHL: t = a << b[5:0];
                        OP_SHR: t = $signed(a) >>> b[5:0];
                        OP_POW:
                            if (b[63]) st = ST_NEG_EXP;
                            else t = wrap_power(a, b);
                        OP_LT:   t = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
                        OP_GT:   t = ($signed(a) > $signed(b)) ? 64'd1 : 64'd0;
                        OP_EQ:   t = (a == b) ? 64'd1 : 64'd0;
                        OP_LAND: t = (a != 0 && b != 0) ? 64'd1 : 64'd0;
                        default: t = (a != 0 || b != 0) ? 64'd1 : 64'd0;
                    endcase
                    if (st == ST_OK)
                    begin
                        sp--;
                        model_stack[sp-1] = t;
                    end
                end
            OP_NOT, OP_LNOT:
                if (sp < 1) st = ST_UNDERFLOW;
                else if (op == OP_NOT) model_stack[sp-1] = ~model_stack[sp-1];
                else model_stack[sp-1] = (model_stack[sp-1] == 0) ? 64'd1 : 64'd0;
            OP_DUP:
                if (sp < 1) st = ST_UNDERFLOW;
                else if (sp >= Depth) st = ST_OVERFLOW;
                else
                begin
                    model_stack[sp] = model_stack[sp-1];
                    sp++;
                end
            OP_OVER:
                if (sp < 3) st = ST_UNDERFLOW;
                else
                begin
                    t = model_stack[sp-1];
                    model_stack[sp-1] = model_stack[sp-3];
                    model_stack[sp-3] = t;
                end
            OP_SWAP:
                if (sp < 2) st = ST_UNDERFLOW;
                else
                begin
                    t = model_stack[sp-1];
                    model_stack[sp-1] = model_stack[sp-2];
                    model_stack[sp-2] = t;
                end
            OP_DEPTH:
                if (sp >= Depth) st = ST_OVERFLOW;
                else
                begin
                    model_stack[sp] = 64'(sp);
                    sp++;
                end
            OP_PICK:
                if (sp < 1) st = ST_UNDERFLOW;
                else
                begin
                    t = model_stack[sp-1];
                    if (t >= 64'(sp - 1)) st = ST_PICK_RANGE;
                    else model_stack[sp-1] = model_stack[t[9:0]];
                end
            default: ;
        endcase
        model_sp = sp;
        res.result_value = popped ? r : ((sp != 0) ? model_stack[sp-1] : 64'd0);
        res.status = st;
        res.stack_depth = 11'(sp);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR at %0t: %s got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Scoreboard: compare each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", out_data.result_value, 64'd0);
            else
            begin
                want = pending_results.pop_front();
                checked_count++;
                if (want.status <= ST_PICK_RANGE)
                    status_seen[want.status]++;
                if (out_data.result_value !== want.result_value)
                    report_mismatch("result_value", out_data.result_value, want.result_value);
                if (out_data.status !== want.status)
                    report_mismatch("status", out_data.status, want.status);
                if (out_data.stack_depth !== want.stack_depth)
                    report_mismatch("stack_depth", out_data.stack_depth, want.stack_depth);
            end
        end
    end

    // Receiver side: stall at random at the current rate.
    always @(posedge clk)
        out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);

    // Sends one operation. The expectation is queued when the transfer happens, which
    // keeps it ahead of the result it causes. A typed-in expectation is compared with
    // the predictor as well, so a wrong table row shows up as a failure too.
    // Valid stays high after a transfer until the next call idles or drives new data.
    task automatic send_op(logic [4:0] op, logic [63:0] pv, bit fixed, out_item_t typed);
        out_item_t predicted;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{op: op, push_value: pv};
        do
            @(posedge clk);
        while (in_stall);
        predicted = stack_op_result(op, pv);
        if (fixed && predicted !== typed)
            report_mismatch("directed table row", predicted.result_value,
                            typed.result_value);
        pending_results.push_back(predicted);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Directed table. The last three columns are the typed-in result, used where
    // the fixed flag is set.
    typedef struct {
        logic [4:0]  op;
        logic [63:0] pv;
        bit          fixed;
        logic [63:0] want_value;
        logic [2:0]  want_status;
        int          want_depth;
    } directed_row_t;

    localparam logic [63:0] MinWord = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MaxWord = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [4:0]  UndefOp = 5'd27;

    directed_row_t directed_rows[] = '{
        '{OP_POP,  0,       1, 0,       ST_UNDERFLOW, 0},
        '{OP_ADD,  0,       1, 0,       ST_UNDERFLOW, 0},
        '{OP_PICK, 0,       1, 0,       ST_UNDERFLOW, 0},
        '{OP_PUSH, MinWord, 1, MinWord, ST_OK,        1},
        '{OP_PUSH, AllOnes, 1, AllOnes, ST_OK,        2},
        '{OP_DIV,  0,       1, MinWord, ST_OK,        1},
        '{OP_PUSH, 0,       1, 0,       ST_OK,        2},
        '{OP_MOD,  0,       1, 0,       ST_DIV_ZERO,  2},
        '{OP_DIV,  0,       1, 0,       ST_DIV_ZERO,  2},
        '{OP_POP,  0,       1, 0,       ST_OK,        1},
        '{OP_PUSH, AllOnes, 1, AllOnes, ST_OK,        2},
        '{OP_POW,  0,       1, AllOnes, ST_NEG_EXP,   2},
        '{OP_MOD,  0,       1, 0,       ST_OK,        1},
        '{OP_PUSH, MaxWord, 1, MaxWord, ST_OK,        2},
        '{OP_PICK, 0,       1, MaxWord, ST_PICK_RANGE, 2},
        '{OP_DEPTH, 0,      1, 2,       ST_OK,        3},
        '{OP_OVER, 0,       0, 0, 0, 0},
        '{OP_SWAP, 0,       0, 0, 0, 0},
        '{OP_SHR,  0,       0, 0, 0, 0},
        '{OP_NOT,  0,       0, 0, 0, 0},
        '{OP_PUSH, 64'd3,   0, 0, 0, 0},
        '{OP_POW,  0,       0, 0, 0, 0},
        '{OP_LNOT, 0,       0, 0, 0, 0},
        '{UndefOp, AllOnes, 0, 0, 0, 0}
    };

    // Random operand: extremes, small counts and full-width words.
    function automatic logic [63:0] random_word();
        case ($urandom_range(5))
            0: return MinWord;
            1: return MaxWord;
            2: return 64'($signed($urandom_range(16)) - 8);
            3: return 64'($urandom_range(70));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random operation, weighted toward a stack that stays populated; an index
    // within range is pushed ahead of most picks.
    task automatic random_op();
        logic [4:0] op;
        int unsigned pick;
        pick = $urandom_range(99);
        if (model_sp < 3 && pick < 50) op = OP_PUSH;
        else if (pick < 3) op = 5'($urandom_range(31, 25));
        else op = 5'($urandom_range(24));
        if (op == OP_PICK && model_sp > 0 && $urandom_range(3) != 0)
            send_op(OP_PUSH, 64'($urandom_range(model_sp - 1)), 1'b0, '0);
        send_op(op, random_word(), 1'b0, '0);
    endtask

    initial
    begin
        out_item_t typed;
        int phase;
        int n;
        int overflow_runs;
        error_count = 0;
        checked_count = 0;
        overflow_runs = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        model_sp = 0;
        foreach (status_seen[k])
            status_seen[k] = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            typed.result_value = directed_rows[k].want_value;
            typed.status = directed_rows[k].want_status;
            typed.stack_depth = 11'(directed_rows[k].want_depth);
            send_op(directed_rows[k].op, directed_rows[k].pv, directed_rows[k].fixed, typed);
        end
        // Hold off the sender until every result is back.
        wait_drained();

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 57 : 0;
            recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 34 : 0;
            for (n = 0; n < RandomOps / 3; n++)
                random_op();
            // In the last phase fill the stack to the top to reach overflow.
            if (phase == 2)
            begin
                while (model_sp < Depth)
                    send_op($urandom_range(1) ? OP_DUP : OP_PUSH, random_word(), 1'b0, '0);
                send_op(OP_PUSH, 0, 1'b0, '0);
                send_op(OP_DUP, 0, 1'b0, '0);
                send_op(OP_DEPTH, 0, 1'b0, '0);
                send_op(OP_PICK, 0, 1'b0, '0);
                overflow_runs++;
            end
        end

        wait_drained();
        repeat (DrainCycles)
            @(posedge clk);
        $display("Checked %0d results; status counts ok %0d, overflow %0d, underflow %0d,",
                 checked_count, status_seen[0], status_seen[1], status_seen[2]);
        $display("negative exponent %0d, divide by zero %0d, pick range %0d; %0d full-stack runs.",
                 status_seen[3], status_seen[4], status_seen[5], overflow_runs);
        if (error_count == 0 && pending_results.size() == 0)
            $display("stack_machine_alu: match");
        else
            $display("stack_machine_alu: mismatch");
        $finish;
    end

    // Safety limit: ends the run as a mismatch if the test hangs.
    initial
    begin
        #40_000_000;
        $display("stack_machine_alu: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
